[rtl/stli_pkg.sv]
`default_nettype none
package stli_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_QSCAN,
        S_QDEC,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic shift;
        logic wr;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/sorted_table_linear_interpolator.sv]
`default_nettype none
// Sorted breakpoint table with piecewise linear interpolation.
// Slave stream (i_s_*) carries commands: tuser is the command (clear, load a
// pair, query), tdata holds key_in (low) and value_in. Master stream (o_m_*)
// returns one beat per command: tdata holds result_value (low) and
// entry_count, tuser holds the status code.
// The table lives in a ring of TABLE_DEPTH cells that rotates one position a
// cycle toward cell 0 while sorting or scanning; sorting and lookup both
// stream the entries past cell 0. Clear, load, an unused code and a query on
// an empty table are answered at the accepting edge; the beat shows on the
// next cycle. A query on a sorted table scans one full rotation, then passes
// a decision state and an output state; when it interpolates, a multiply
// state, a divider start state, the divider's run and a sum state come in
// between. The first query after loads first runs a selection sort of
// (held+1) passes, each one full rotation.
// One command is in flight at a time. Reset empties the table and marks it
// sorted; no clearing pass is run. A stalled receiver holds the result in the
// output register; a command is taken only while that register is free or
// being drained, and longer commands wait for it at their end.
module sorted_table_linear_interpolator #(
    parameter int TABLE_DEPTH = stli_pkg::TABLE_DEPTH_DEF,
    parameter int DATA_WIDTH  = stli_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // key_in, value_in from bit 0 up, zero padded to bytes
    input  wire logic [((2*DATA_WIDTH+7)/8)*8-1:0] i_s_tdata,
    // command
    input  wire logic [1:0]            i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // result_value, entry_count from bit 0 up, zero padded to bytes
    output logic [((DATA_WIDTH+$clog2(TABLE_DEPTH+1)+7)/8)*8-1:0] o_m_tdata,
    // status
    output logic [1:0]                 o_m_tuser
);

    localparam int DW  = DATA_WIDTH;
    localparam int EW  = 2 * DW;
    localparam int PW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int NW  = 2 * DW + 2;
    localparam int OTW = ((DW + CW + 7) / 8) * 8;
    localparam logic signed [NW+1:0] SAT_HI = {{(NW + 3 - DW){1'b0}}, {(DW - 1){1'b1}}};
    localparam logic signed [NW+1:0] SAT_LO = {{(NW + 3 - DW){1'b1}}, {(DW - 1){1'b0}}};

    stli_pkg::t_state r_state, n_state;

    // control registers
    logic [CW-1:0] r_held;
    logic          r_sorted;
    logic [CW-1:0] r_pass;
    logic [PW-1:0] r_pos;
    logic          r_fvalid;
    logic          r_hit;
    logic          r_m_valid;

    // payload registers
    logic signed [DW-1:0] r_q;
    logic signed [DW-1:0] r_fk, r_fv, r_sk, r_sv, r_tk, r_tv;
    logic [PW-1:0]        r_fi, r_smi;
    logic signed [DW-1:0] r_k0, r_v0, r_kl, r_hv;
    logic signed [DW-1:0] r_ka, r_va, r_kb, r_vb;
    logic signed [NW-1:0] r_prod;
    logic [DW:0]          r_den;
    logic [NW-1:0]        r_quo;
    logic [DW-1:0]        r_res;
    logic [1:0]           r_st;
    logic [DW-1:0]        r_m_res;
    logic [1:0]           r_m_st;
    logic [CW-1:0]        r_m_cnt;

    // beat fields
    logic [1:0]    w_cmd;
    logic [DW-1:0] w_key, w_val;
    logic          w_acc;
    logic          w_imm;

    // ring
    logic [EW-1:0]       w_cell_q [TABLE_DEPTH];
    logic [EW-1:0]       w_fb;
    logic signed [DW-1:0] w_h0k, w_h0v, w_h1k, w_h1v, w_fbk, w_fbv;
    logic [CW-1:0]       w_pos_ext, w_pos_nx;
    logic                w_rot_end;
    logic                w_sw_here, w_sw_mi;
    logic                w_srch, w_take;
    logic signed [DW-1:0] w_fk_nx, w_fv_nx;
    logic [PW-1:0]       w_fi_nx;

    // control outputs
    logic w_shift;
    logic w_ld_wr;
    logic w_div_start;

    // arithmetic
    logic signed [DW:0]   w_dq, w_dv;
    logic [NW-1:0]        w_mag;
    logic                 w_div_done;
    logic [NW-1:0]        w_div_q;
    logic signed [NW:0]   w_sq;
    logic signed [NW+1:0] w_sum;
    logic [DW-1:0]        w_sat;

    assign w_cmd = i_s_tuser;
    assign w_key = i_s_tdata[DW-1:0];
    assign w_val = i_s_tdata[EW-1:DW];
    assign w_acc = i_s_tvalid && o_s_tready;
    // everything but a query on a non-empty table answers at once
    assign w_imm = w_acc && !((w_cmd == stli_pkg::CMD_QUERY) && (r_held != '0));

    // ---------------- ring of cells ----------------
    assign w_h0k = w_cell_q[0][DW-1:0];
    assign w_h0v = w_cell_q[0][EW-1:DW];
    assign w_h1k = w_cell_q[1][DW-1:0];
    assign w_h1v = w_cell_q[1][EW-1:DW];

    assign w_pos_ext = CW'(r_pos);
    assign w_pos_nx  = w_pos_ext + CW'(1);
    assign w_rot_end = (r_pos == PW'(TABLE_DEPTH - 1));

    // finish the previous selection pass as its slots pass cell 0: min into
    // the pass slot, the displaced entry into the slot the min came from
    assign w_sw_here = (r_state == stli_pkg::S_SORT) && (r_pass != '0)
                       && (w_pos_ext == r_pass - CW'(1));
    assign w_sw_mi   = (r_state == stli_pkg::S_SORT) && (r_pass != '0)
                       && !w_sw_here && (r_pos == r_smi);
    assign w_fb = w_sw_here ? {r_sv, r_sk} :
                  w_sw_mi   ? {r_tv, r_tk} : w_cell_q[0];
    assign w_fbk = w_fb[DW-1:0];
    assign w_fbv = w_fb[EW-1:DW];

    // search the current pass over post-swap entries; first smallest wins
    assign w_srch = (r_state == stli_pkg::S_SORT) && (r_pass < r_held)
                    && (w_pos_ext >= r_pass) && (w_pos_ext < r_held);
    assign w_take  = w_srch && (!r_fvalid || (w_fbk < r_fk));
    assign w_fk_nx = w_take ? w_fbk : r_fk;
    assign w_fv_nx = w_take ? w_fbv : r_fv;
    assign w_fi_nx = w_take ? r_pos : r_fi;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        stli_pkg::t_cell_ctl w_ctl;
        logic [EW-1:0]       w_din;
        assign w_ctl = '{shift: w_shift, wr: w_ld_wr && (r_held == CW'(g))};
        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_din = w_fb;
        end else begin : g_body
            assign w_din = w_cell_q[g+1];
        end
        stli_cell #(.EW(EW)) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_din   (w_din),
            .i_wdata ({w_val, w_key}),
            .o_q     (w_cell_q[g])
        );
    end

    // ---------------- arithmetic ----------------
    assign w_dq  = {r_q[DW-1], r_q} - {r_ka[DW-1], r_ka};
    assign w_dv  = {r_vb[DW-1], r_vb} - {r_va[DW-1], r_va};
    assign w_mag = r_prod[NW-1] ? NW'(-r_prod) : NW'(r_prod);

    stli_div #(.NW(NW), .DVW(DW + 1)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mag),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // quotient truncates toward zero: negate the magnitude quotient
    assign w_sq  = r_prod[NW-1] ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum = {{(NW + 2 - DW){r_va[DW-1]}}, r_va} + {w_sq[NW], w_sq};
    assign w_sat = (w_sum > SAT_HI) ? SAT_HI[DW-1:0] :
                   (w_sum < SAT_LO) ? SAT_LO[DW-1:0] : w_sum[DW-1:0];

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            stli_pkg::S_IDLE: begin
                if (w_acc && (w_cmd == stli_pkg::CMD_QUERY) && (r_held != '0)) begin
                    n_state = r_sorted ? stli_pkg::S_QSCAN : stli_pkg::S_SORT;
                end
            end
            stli_pkg::S_SORT: begin
                if (w_rot_end && (r_pass == r_held)) begin
                    n_state = stli_pkg::S_QSCAN;
                end
            end
            stli_pkg::S_QSCAN: begin
                if (w_rot_end) begin
                    n_state = stli_pkg::S_QDEC;
                end
            end
            stli_pkg::S_QDEC: begin
                if ((r_q < r_k0) || (r_q > r_kl) || r_hit || (r_held < CW'(2))) begin
                    n_state = stli_pkg::S_OUT;
                end else begin
                    n_state = stli_pkg::S_MUL;
                end
            end
            stli_pkg::S_MUL:       n_state = stli_pkg::S_DIV_START;
            stli_pkg::S_DIV_START: n_state = stli_pkg::S_DIV_WAIT;
            stli_pkg::S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_state = stli_pkg::S_SUM;
                end
            end
            stli_pkg::S_SUM:       n_state = stli_pkg::S_OUT;
            stli_pkg::S_OUT: begin
                if (!r_m_valid) begin
                    n_state = stli_pkg::S_IDLE;
                end
            end
            default:               n_state = stli_pkg::S_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        o_s_tready  = 1'b0;
        w_shift     = 1'b0;
        w_ld_wr     = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            stli_pkg::S_IDLE: begin
                o_s_tready = !r_m_valid || i_m_tready;
                w_ld_wr    = w_acc && (w_cmd == stli_pkg::CMD_LOAD)
                             && (r_held < CW'(TABLE_DEPTH));
            end
            stli_pkg::S_SORT:      w_shift     = 1'b1;
            stli_pkg::S_QSCAN:     w_shift     = 1'b1;
            stli_pkg::S_DIV_START: w_div_start = 1'b1;
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= stli_pkg::S_IDLE;
            r_held    <= '0;
            r_sorted  <= 1'b1;
            r_pass    <= '0;
            r_pos     <= '0;
            r_fvalid  <= 1'b0;
            r_hit     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_imm || ((r_state == stli_pkg::S_OUT) && !r_m_valid)) begin
                r_m_valid <= 1'b1;
            end
            if (w_acc) begin
                if (w_cmd == stli_pkg::CMD_CLEAR) begin
                    r_held   <= '0;
                    r_sorted <= 1'b1;
                end else if (w_ld_wr) begin
                    r_held   <= r_held + CW'(1);
                    r_sorted <= 1'b0;
                end
                r_pass   <= '0;
                r_pos    <= '0;
                r_fvalid <= 1'b0;
                r_hit    <= 1'b0;
            end
            if (w_shift) begin
                r_pos <= w_rot_end ? '0 : r_pos + PW'(1);
            end
            if (r_state == stli_pkg::S_SORT) begin
                r_fvalid <= w_rot_end ? 1'b0 : (r_fvalid || w_take);
                if (w_rot_end) begin
                    r_pass <= r_pass + CW'(1);
                    if (r_pass == r_held) begin
                        r_sorted <= 1'b1;
                    end
                end
            end
            if ((r_state == stli_pkg::S_QSCAN) && (w_pos_nx < r_held) && !r_hit) begin
                if ((w_h0k == r_q) || (w_h1k == r_q)) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q <= w_key;
        end
        if (w_sw_here) begin
            r_tk <= w_h0k;
            r_tv <= w_h0v;
        end
        if (r_state == stli_pkg::S_SORT) begin
            r_fk <= w_fk_nx;
            r_fv <= w_fv_nx;
            r_fi <= w_fi_nx;
            if (w_rot_end) begin
                r_sk  <= w_fk_nx;
                r_sv  <= w_fv_nx;
                r_smi <= w_fi_nx;
            end
        end
        if (r_state == stli_pkg::S_QSCAN) begin
            if (r_pos == '0) begin
                r_k0 <= w_h0k;
                r_v0 <= w_h0v;
            end
            if (w_pos_nx == r_held) begin
                r_kl <= w_h0k;
            end
            if ((w_pos_nx < r_held) && !r_hit) begin
                if (w_h0k == r_q) begin
                    r_hv <= w_h0v;
                end else if (w_h1k == r_q) begin
                    r_hv <= w_h1v;
                end
                if ((w_h0k < r_q) && (w_h1k > r_q)) begin
                    r_ka <= w_h0k;
                    r_va <= w_h0v;
                    r_kb <= w_h1k;
                    r_vb <= w_h1v;
                end
            end
        end
        if (r_state == stli_pkg::S_QDEC) begin
            if ((r_q < r_k0) || (r_q > r_kl)) begin
                r_res <= '0;
                r_st  <= stli_pkg::STAT_RANGE;
            end else begin
                r_res <= r_hit ? r_hv : r_v0;
                r_st  <= stli_pkg::STAT_OK;
            end
        end
        if (r_state == stli_pkg::S_MUL) begin
            r_prod <= w_dq * w_dv;
            r_den  <= {r_kb[DW-1], r_kb} - {r_ka[DW-1], r_ka};
        end
        if ((r_state == stli_pkg::S_DIV_WAIT) && w_div_done) begin
            r_quo <= w_div_q;
        end
        if (r_state == stli_pkg::S_SUM) begin
            r_res <= w_sat;
            r_st  <= stli_pkg::STAT_OK;
        end
        // drive the output register: immediate answers, or the pending query result
        if (w_imm) begin
            r_m_res <= '0;
            r_m_cnt <= r_held;
            r_m_st  <= stli_pkg::STAT_OK;
            if (w_cmd == stli_pkg::CMD_CLEAR) begin
                r_m_cnt <= '0;
            end else if (w_cmd == stli_pkg::CMD_LOAD) begin
                if (r_held < CW'(TABLE_DEPTH)) begin
                    r_m_cnt <= r_held + CW'(1);
                end else begin
                    r_m_st <= stli_pkg::STAT_FULL;
                end
            end else if (w_cmd == stli_pkg::CMD_QUERY) begin
                r_m_st <= stli_pkg::STAT_EMPTY;
            end
        end else if ((r_state == stli_pkg::S_OUT) && !r_m_valid) begin
            r_m_res <= r_res;
            r_m_st  <= r_st;
            r_m_cnt <= r_held;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = OTW'({r_m_cnt, r_m_res});
    assign o_m_tuser  = r_m_st;

    // ---------------- assertions ----------------
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> (!r_m_valid || i_m_tready))
        else $error("beat accepted while output register is held");

    a_busy_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != stli_pkg::S_IDLE) |-> !o_s_tready)
        else $error("ready raised during a query");

    a_sort_unsorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stli_pkg::S_SORT) |-> !r_sorted)
        else $error("sorting a table marked sorted");

endmodule
`default_nettype wire

[rtl/stli_cell.sv]
`default_nettype none
module stli_cell #(
    parameter int EW = 2 * stli_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire stli_pkg::t_cell_ctl i_ctl,
    input  wire logic [EW-1:0]       i_din,
    input  wire logic [EW-1:0]       i_wdata,
    output logic      [EW-1:0]       o_q
);

    logic [EW-1:0] r_entry;

    // shift wins; a write only lands while the ring is at rest
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_entry <= i_din;
        end else if (i_ctl.wr) begin
            r_entry <= i_wdata;
        end
    end

    assign o_q = r_entry;

endmodule
`default_nettype wire

[rtl/stli_div.sv]
`default_nettype none
module stli_div #(
    parameter int NW  = 2 * stli_pkg::DATA_WIDTH_DEF + 2,
    parameter int DVW = stli_pkg::DATA_WIDTH_DEF + 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_dividend,
    input  wire logic [DVW-1:0] i_divisor,
    output logic                o_done,
    output logic      [NW-1:0]  o_quotient
);

    localparam int CTW = $clog2(NW);

    logic           r_busy;
    logic           r_done;
    logic [CTW-1:0] r_cnt;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_den;
    logic [NW-1:0]  r_q;

    logic [DVW:0]   w_sh;
    logic [DVW:0]   w_diff;
    logic           w_ge;

    // restoring step: one quotient bit per cycle
    assign w_sh   = {r_rem, r_q[NW-1]};
    assign w_diff = w_sh - {1'b0, r_den};
    assign w_ge   = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CTW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + CTW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DVW-1:0] : w_sh[DVW-1:0];
            r_q   <= {r_q[NW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire
